[src/ffba_pkg.sv]
// Shared constants, types and helpers of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int CELLS   = 128;
    localparam int ID_BITS = 16;

    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W   = $clog2(CELLS + 1);

    localparam int OP_W    = 2;
    localparam int SIZE_W  = 8;
    localparam int EID_W   = 16;
    localparam int ST_W    = 2;
    localparam int BLK_W   = 16;
    localparam int CFG_W   = 8;

    localparam int SZ_W    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int CMP_W   = (ID_BITS > EID_W) ? ID_BITS : EID_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_MEM_SIZE = '0;
    localparam logic [CFG_W-1:0]   MEM_SIZE_RST = 8'd128;
    localparam logic [ID_BITS-1:0] ID_MAX       = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_ERASE  = 2'd1,
        OP_DEFRAG = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_ALLOC   = 2'd0,
        ST_NULL    = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic [ID_BITS-1:0] wdata;
        logic               re;
        logic [CELL_AW-1:0] raddr;
    } t_ram_req;

    function automatic logic [BLK_W-1:0] id_to_blk(input logic [ID_BITS-1:0] id);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(id);
        return wide[BLK_W-1:0];
    endfunction

endpackage
`default_nettype wire

[src/ffba_if.sv]
// Request and response channel interfaces of the allocator.
`default_nettype none
interface ffba_req_if;
    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::OP_W-1:0]     operation;
    logic [ffba_pkg::SIZE_W-1:0]   alloc_size;
    logic [ffba_pkg::EID_W-1:0]    erase_id;

    modport source (output valid, output operation, output alloc_size, output erase_id,
                    input ready);
    modport sink   (input valid, input operation, input alloc_size, input erase_id,
                    output ready);
endinterface

interface ffba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::ST_W-1:0]     status;
    logic [ffba_pkg::BLK_W-1:0]    block_id;

    modport source (output valid, output status, output block_id, input ready);
    modport sink   (input valid, input status, input block_id, output ready);
endinterface
`default_nettype wire

[src/ffba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[src/ffba_cfg.sv]
// APB register file holding the mem_size register.
`default_nettype none
module ffba_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ffba_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ffba_pkg::PDATA_W-1:0]   pwdata,
    output      logic [ffba_pkg::PDATA_W-1:0]   prdata,
    output      logic                           pready,
    output      logic [ffba_pkg::CFG_W-1:0]     o_mem_size
);

    logic [ffba_pkg::CFG_W-1:0] r_mem_size;
    logic [ffba_pkg::CFG_W-1:0] n_mem_size;
    logic                       w_sel_size;

    assign w_sel_size = (paddr[ffba_pkg::PADDR_W-1:2] == ffba_pkg::REG_MEM_SIZE);

    always_comb begin
        n_mem_size = r_mem_size;
        if (psel && penable && pwrite && w_sel_size) begin
            n_mem_size = pwdata[ffba_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= ffba_pkg::MEM_SIZE_RST;
        end else begin
            r_mem_size <= n_mem_size;
        end
    end

    assign prdata     = w_sel_size ? ffba_pkg::PDATA_W'(r_mem_size) : '0;
    assign pready     = 1'b1;
    assign o_mem_size = r_mem_size;

endmodule
`default_nettype wire

[src/ffba_engine.sv]
// Request sequencer: scans and rewrites the cell owner memory, holds the response.
`default_nettype none
module ffba_engine (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [ffba_pkg::CFG_W-1:0]       i_mem_size,
    ffba_req_if.sink                              i_req,
    ffba_rsp_if.source                            o_rsp,
    output      ffba_pkg::t_ram_req               o_ram,
    input  wire logic [ffba_pkg::ID_BITS-1:0]     i_ram_rdata
);

    localparam int AW  = ffba_pkg::CELL_AW;
    localparam int CW  = ffba_pkg::CNT_W;
    localparam int SW  = ffba_pkg::SZ_W;
    localparam int MW  = ffba_pkg::CMP_W;
    localparam int IW  = ffba_pkg::ID_BITS;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ASCAN = 8'b0000_0100,
        S_AFILL = 8'b0000_1000,
        S_ESCAN = 8'b0001_0000,
        S_DSCAN = 8'b0010_0000,
        S_DFILL = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_addr, n_addr;
    logic                         r_pend, n_pend;
    logic [AW-1:0]                r_ppos, n_ppos;
    logic [CW-1:0]                r_run, n_run;
    logic [CW-1:0]                r_wr, n_wr;
    logic [CW-1:0]                r_end, n_end;
    logic [CW-1:0]                r_m, n_m;
    logic [ffba_pkg::SIZE_W-1:0]  r_need, n_need;
    logic [ffba_pkg::EID_W-1:0]   r_id, n_id;
    logic                         r_hit, n_hit;
    logic [IW-1:0]                r_last, n_last;
    ffba_pkg::t_status            r_status, n_status;
    logic [ffba_pkg::BLK_W-1:0]   r_blk, n_blk;
    logic                         r_ovld, n_ovld;
    ffba_pkg::t_status            r_ostat, n_ostat;
    logic [ffba_pkg::BLK_W-1:0]   r_oblk, n_oblk;

    logic [SW-1:0]                w_size_wide;
    logic [CW-1:0]                w_m_eff;
    logic                         w_scan;
    logic                         w_issue;
    logic                         w_scan_end;
    logic                         w_rd_zero;
    logic [CW-1:0]                w_run_n;
    logic [SW-1:0]                w_start;

    assign w_size_wide = (SW'(i_mem_size) < SW'(ffba_pkg::CELLS))
                         ? SW'(i_mem_size) : SW'(ffba_pkg::CELLS);
    assign w_m_eff     = w_size_wide[CW-1:0];

    assign w_scan     = (r_state == S_ASCAN) || (r_state == S_ESCAN) || (r_state == S_DSCAN);
    assign w_issue    = w_scan && (r_addr < r_m);
    assign w_scan_end = !r_pend && (r_addr >= r_m);
    assign w_rd_zero  = (i_ram_rdata == '0);
    assign w_run_n    = w_rd_zero ? (r_run + CW'(1)) : '0;
    assign w_start    = SW'(r_ppos) + SW'(1) - SW'(r_need);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_pend   = 1'b0;
        n_ppos   = r_ppos;
        n_run    = r_run;
        n_wr     = r_wr;
        n_end    = r_end;
        n_m      = r_m;
        n_need   = r_need;
        n_id     = r_id;
        n_hit    = r_hit;
        n_last   = r_last;
        n_status = r_status;
        n_blk    = r_blk;
        n_ovld   = r_ovld;
        n_ostat  = r_ostat;
        n_oblk   = r_oblk;
        o_ram    = '0;

        if (r_ovld && o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        if (w_issue) begin
            o_ram.re    = 1'b1;
            o_ram.raddr = r_addr[AW-1:0];
            n_addr      = r_addr + CW'(1);
            n_pend      = 1'b1;
            n_ppos      = r_addr[AW-1:0];
        end

        unique case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr[AW-1:0];
                o_ram.wdata = '0;
                n_addr      = r_addr + CW'(1);
                if (r_addr == CW'(ffba_pkg::CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_need   = i_req.alloc_size;
                    n_id     = i_req.erase_id;
                    n_m      = w_m_eff;
                    n_addr   = '0;
                    n_run    = '0;
                    n_wr     = '0;
                    n_hit    = 1'b0;
                    n_blk    = '0;
                    n_status = ffba_pkg::ST_DONE;
                    n_state  = S_RESP;
                    case (i_req.operation)
                        ffba_pkg::OP_ALLOC: begin
                            if (i_req.alloc_size == '0 || r_last == ffba_pkg::ID_MAX
                                || w_m_eff == '0) begin
                                n_status = ffba_pkg::ST_NULL;
                            end else begin
                                n_state = S_ASCAN;
                            end
                        end
                        ffba_pkg::OP_ERASE: begin
                            if (i_req.erase_id == '0 || w_m_eff == '0) begin
                                n_status = ffba_pkg::ST_ILLEGAL;
                            end else begin
                                n_state = S_ESCAN;
                            end
                        end
                        ffba_pkg::OP_DEFRAG: begin
                            if (w_m_eff != '0) begin
                                n_state = S_DSCAN;
                            end
                        end
                        default: begin
                            n_status = ffba_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_ASCAN: begin
                if (r_pend) begin
                    n_run = w_run_n;
                    if (SW'(w_run_n) == SW'(r_need)) begin
                        n_wr    = w_start[CW-1:0];
                        n_end   = CW'(r_ppos) + CW'(1);
                        n_last  = r_last + IW'(1);
                        n_state = S_AFILL;
                    end
                end else if (w_scan_end) begin
                    n_status = ffba_pkg::ST_NULL;
                    n_state  = S_RESP;
                end
            end
            S_AFILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_wr[AW-1:0];
                o_ram.wdata = r_last;
                n_wr        = r_wr + CW'(1);
                if (r_wr + CW'(1) == r_end) begin
                    n_status = ffba_pkg::ST_ALLOC;
                    n_blk    = ffba_pkg::id_to_blk(r_last);
                    n_state  = S_RESP;
                end
            end
            S_ESCAN: begin
                if (r_pend && MW'(i_ram_rdata) == MW'(r_id)) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_ppos;
                    o_ram.wdata = '0;
                    n_hit       = 1'b1;
                end
                if (w_scan_end) begin
                    n_status = r_hit ? ffba_pkg::ST_DONE : ffba_pkg::ST_ILLEGAL;
                    n_state  = S_RESP;
                end
            end
            S_DSCAN: begin
                if (r_pend && !w_rd_zero) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_wr[AW-1:0];
                    o_ram.wdata = i_ram_rdata;
                    n_wr        = r_wr + CW'(1);
                end
                if (w_scan_end) begin
                    n_status = ffba_pkg::ST_DONE;
                    n_state  = (r_wr < r_m) ? S_DFILL : S_RESP;
                end
            end
            S_DFILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_wr[AW-1:0];
                o_ram.wdata = '0;
                n_wr        = r_wr + CW'(1);
                if (r_wr + CW'(1) == r_m) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld  = 1'b1;
                    n_ostat = r_status;
                    n_oblk  = r_blk;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_addr  = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_last  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_last  <= n_last;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ppos   <= n_ppos;
        r_run    <= n_run;
        r_wr     <= n_wr;
        r_end    <= n_end;
        r_m      <= n_m;
        r_need   <= n_need;
        r_id     <= n_id;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_blk    <= n_blk;
        r_ostat  <= n_ostat;
        r_oblk   <= n_oblk;
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ovld;
    assign o_rsp.status   = r_ostat;
    assign o_rsp.block_id = r_oblk;

endmodule
`default_nettype wire

[src/first_fit_block_allocator.sv]
// First-fit contiguous block allocator with compaction: top level.
//
// Requests arrive on i_req (operation, alloc_size, erase_id) under a valid/ready
// handshake; every request yields exactly one response on o_rsp (status,
// block_id). mem_size is written over the APB port at byte address 0; the user
// is to write it only while the block is idle; the block itself does not enforce
// this. pready is always high. Cell owners live in one single-port-write,
// single-port-read RAM with registered read data. Each non-trivial request is
// one read-modify-write sweep of that RAM's first min(mem_size, CELLS) cells,
// one cell per cycle: alloc scans, then fills the run found; erase frees the
// cells of the given id; defragment packs, then frees the tail. Trivial requests
// (null alloc, illegal erase, unused code) go straight to the response.
// One request is in work at a time; a new request is taken while the previous
// response still waits in the output register.
// After reset the RAM is cleared cell by cell; i_req.ready stays low during
// that sweep, while APB writes are taken as usual.
// When o_rsp is stalled the response holds and the next request finishes its
// sweep, then waits before returning to idle.
`default_nettype none
module first_fit_block_allocator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ffba_req_if.sink                            i_req,
    ffba_rsp_if.source                          o_rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ffba_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ffba_pkg::PDATA_W-1:0]   pwdata,
    output      logic [ffba_pkg::PDATA_W-1:0]   prdata,
    output      logic                           pready
);

    logic [ffba_pkg::CFG_W-1:0]   w_mem_size;
    ffba_pkg::t_ram_req           w_ram;
    logic [ffba_pkg::ID_BITS-1:0] w_ram_rdata;

    ffba_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_mem_size (w_mem_size)
    );

    ffba_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mem_size  (w_mem_size),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram       (w_ram),
        .i_ram_rdata (w_ram_rdata)
    );

    ffba_ram #(
        .WIDTH (ffba_pkg::ID_BITS),
        .DEPTH (ffba_pkg::CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
`default_nettype wire
